// ----- rtl/core/sfdc_pkg.sv -----
// Shared types and constants for the serial frame deframer.
// Used by serial_frame_deframer_checksum_unit; no other dependencies.
package sfdc_pkg;

  localparam int MaxCmd     = 64;
  localparam int LenMax     = MaxCmd - 4;   // largest length byte that is accepted
  localparam int StoreDepth = 64;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int IdxW       = 6;

  typedef enum logic [1:0] {
    ST_RX,    // taking input words
    ST_RD,    // frame store read in flight
    ST_OUT,   // frame byte presented
    ST_ERR    // checksum error presented
  } state_t;

endpackage

// ----- rtl/core/serial_frame_deframer_checksum_unit.sv -----
// Serial frame deframer: header hunt, length check, 8-bit additive checksum.
// Frame bytes are held in a 64-entry synchronous store; uses sfdc_pkg.
//
//  channel  direction  handshake                 payload
//  input    in         in_valid / in_stall       rx_byte
//  output   out        out_valid / out_stall     frame_byte, byte_index, status, last
//  config   in         cfg_we                    head_byte
//
// Each word taken into a frame is written to the frame store.
// A good frame is read back and emitted word by word, each through ST_RD for
// the store read and then ST_OUT to present the word (single read port).
// A checksum error gives one result word. Input is stalled while a frame is
// emitted. Reset (rst, synchronous) clears control state only; the store
// needs no clearing since only entries of the current frame are read.
module serial_frame_deframer_checksum_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [7:0]              head_byte,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              rx_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              frame_byte,
  output logic [sfdc_pkg::IdxW-1:0] byte_index,
  output logic                    status,
  output logic                    last
);

  sfdc_pkg::state_t state, state_next;

  logic [7:0]                    head_value;
  logic [sfdc_pkg::IdxW-1:0]     position, position_next;
  logic [sfdc_pkg::IdxW-1:0]     length_target, length_next;
  logic [7:0]                    running_sum, sum_next;
  logic [sfdc_pkg::AddrW-1:0]    emit_idx, idx_next;
  logic [sfdc_pkg::AddrW-1:0]    emit_last, last_next;

  logic [sfdc_pkg::IdxW-1:0]     len_cur;
  logic [sfdc_pkg::IdxW-1:0]     frame_end;

  logic                          wr_en;
  logic [sfdc_pkg::AddrW-1:0]    wr_addr;
  logic [7:0]                    wr_data;
  logic [7:0]                    rd_data;
  logic [7:0]                    mem [sfdc_pkg::StoreDepth];

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == sfdc_pkg::ST_RD) begin
      rd_data <= mem[emit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sfdc_pkg::ST_RX;
      head_value    <= '0;
      position      <= '0;
      length_target <= '0;
      running_sum   <= '0;
      emit_idx      <= '0;
      emit_last     <= '0;
    end else begin
      state         <= state_next;
      position      <= position_next;
      length_target <= length_next;
      running_sum   <= sum_next;
      emit_idx      <= idx_next;
      emit_last     <= last_next;
      if (cfg_we) begin
        head_value <= head_byte;
      end
    end
  end

  // length comes from the word itself when it is the length byte
  assign len_cur   = (position == sfdc_pkg::IdxW'(1)) ? rx_byte[sfdc_pkg::IdxW-1:0]
                                                    : length_target;
  assign frame_end = sfdc_pkg::IdxW'(len_cur + sfdc_pkg::IdxW'(1));

  always_comb begin
    state_next    = state;
    position_next = position;
    length_next   = length_target;
    sum_next      = running_sum;
    idx_next      = emit_idx;
    last_next     = emit_last;
    wr_en         = 1'b0;
    wr_addr       = sfdc_pkg::AddrW'(position);
    wr_data       = rx_byte;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    case (state)
      sfdc_pkg::ST_RX: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (position == '0) begin
            if (rx_byte == head_value) begin
              wr_en         = 1'b1;
              wr_addr       = '0;
              position_next = sfdc_pkg::IdxW'(1);
              sum_next      = '0;
              length_next   = '0;
            end
          end else if (position == sfdc_pkg::IdxW'(1) &&
                       rx_byte > 8'(sfdc_pkg::LenMax)) begin
            // oversized length: drop header and length, hunt again
            position_next = '0;
            length_next   = '0;
            sum_next      = '0;
          end else begin
            wr_en = 1'b1;
            if (position == frame_end) begin
              position_next = '0;
              length_next   = '0;
              sum_next      = '0;
              idx_next      = '0;
              last_next     = sfdc_pkg::AddrW'(position);
              state_next    = (running_sum == rx_byte) ? sfdc_pkg::ST_RD
                                                       : sfdc_pkg::ST_ERR;
            end else begin
              sum_next      = 8'(running_sum + rx_byte);
              position_next = sfdc_pkg::IdxW'(position + sfdc_pkg::IdxW'(1));
              length_next   = len_cur;
            end
          end
        end
      end
      sfdc_pkg::ST_RD: begin
        state_next = sfdc_pkg::ST_OUT;
      end
      sfdc_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (emit_idx == emit_last) begin
            state_next = sfdc_pkg::ST_RX;
          end else begin
            idx_next   = sfdc_pkg::AddrW'(emit_idx + sfdc_pkg::AddrW'(1));
            state_next = sfdc_pkg::ST_RD;
          end
        end
      end
      sfdc_pkg::ST_ERR: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = sfdc_pkg::ST_RX;
        end
      end
      default: begin
        state_next = sfdc_pkg::ST_RX;
      end
    endcase
  end

  assign frame_byte = (state == sfdc_pkg::ST_ERR) ? 8'd0 : rd_data;
  assign byte_index = (state == sfdc_pkg::ST_ERR) ? '0 : sfdc_pkg::IdxW'(emit_idx);
  assign status     = (state == sfdc_pkg::ST_ERR);
  assign last       = (state == sfdc_pkg::ST_ERR) || (emit_idx == emit_last);

`ifndef SYNTH
  // read pointer never runs past the end of the frame being emitted
  a_idx_in_frame: assert property (@(posedge clk) disable iff (rst)
    state == sfdc_pkg::ST_OUT |-> emit_idx <= emit_last)
    else $error("emit index beyond frame end");

  // a word taken while hunting never produces a result on the next cycle
  a_hunt_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && position == '0 |=> !out_valid)
    else $error("result after a hunt word");

  // the final word of a frame or an error returns the block to input
  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> state == sfdc_pkg::ST_RX && position == '0)
    else $error("block not back to input after last word");

  // checksum check leaves frame state cleared
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    state == sfdc_pkg::ST_RD |-> position == '0 && running_sum == '0)
    else $error("frame state not cleared during emit");
`endif

endmodule
